// ===== rtl/adnr_pkg.sv =====
`default_nettype none
// ============================================================================
// adnr_pkg - shared types and constants for the Art-Net DMX receiver
// Holds the word layouts, status codes, header offsets and the magic table.
// ============================================================================
package adnr_pkg;

    // Sizing
    localparam int MAX_SLOTS     = 512;   // last DMX slot that is written
    localparam int PKT_BUF_BYTES = 2048;  // receive buffer size in bytes

    // Header layout
    localparam logic [10:0] POS_MAX       = 11'h7ff;
    localparam logic [10:0] MIN_LEN       = 11'd13;
    localparam logic [10:0] HDR_LEN       = 11'd18;
    localparam logic [15:0] DMX_OPCODE    = 16'h5000;
    localparam logic [15:0] PROTO_VERSION = 16'd14;

    localparam logic [10:0] POS_OPC_LO  = 11'd8;
    localparam logic [10:0] POS_OPC_HI  = 11'd9;
    localparam logic [10:0] POS_VER_HI  = 11'd10;
    localparam logic [10:0] POS_VER_LO  = 11'd11;
    localparam logic [10:0] POS_UNI_LO  = 11'd14;
    localparam logic [10:0] POS_UNI_HI  = 11'd15;
    localparam logic [10:0] POS_LEN_HI  = 11'd16;
    localparam logic [10:0] POS_LEN_LO  = 11'd17;

    // Largest length the buffer can hold
    localparam int EFF_CAP = (PKT_BUF_BYTES - 1 < 2047) ? (PKT_BUF_BYTES - 1) : 2047;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [10:0] packet_length;
    } in_word_t;

    typedef struct packed {
        logic        slot_write;
        logic [9:0]  slot_number;
        logic [7:0]  slot_value;
        logic        packet_done;
        status_t     packet_status;
    } out_word_t;

    // "Art-Net" followed by a zero byte
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h41;
            3'd1:    val = 8'h72;
            3'd2:    val = 8'h74;
            3'd3:    val = 8'h2d;
            3'd4:    val = 8'h4e;
            3'd5:    val = 8'h65;
            3'd6:    val = 8'h74;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/adnr_parse.sv =====
`default_nettype none
// ============================================================================
// adnr_parse - per-byte header check and slot mapping
// Keeps the packet tracking state and turns one input word into at most one
// output word.
// ============================================================================
module adnr_parse (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  fire,
    input  adnr_pkg::in_word_t   word,
    input  wire [14:0]           target_universe,
    output logic                 res_valid,
    output adnr_pkg::out_word_t  res
);
    import adnr_pkg::*;

    logic [10:0] pos_reg, pos_next;
    status_t     rej_reg, rej_next;
    logic [15:0] opc_reg, opc_next;
    logic [7:0]  held_reg, held_next;
    logic        fwd_reg, fwd_next;

    logic        start;
    logic [10:0] p;
    logic [10:0] eff_len;
    logic [10:0] slot_full;
    logic [11:0] got;
    logic [15:0] word16;
    logic [14:0] uni;
    status_t     rej_base;
    logic        wr;

    always_comb
    begin
        start   = word.first_byte || (pos_reg == '0);
        p       = start ? '0 : pos_reg;
        eff_len = (int'(word.packet_length) > EFF_CAP) ? 11'(EFF_CAP) : word.packet_length;

        if (start)
        begin
            rej_base  = (word.packet_length < MIN_LEN) ? ST_SHORT : ST_OK;
            opc_next  = '0;
            held_next = '0;
            fwd_next  = 1'b0;
        end
        else
        begin
            rej_base  = rej_reg;
            opc_next  = opc_reg;
            held_next = held_reg;
            fwd_next  = fwd_reg;
        end

        rej_next  = rej_base;
        wr        = 1'b0;
        slot_full = p - (HDR_LEN - 11'd1);
        word16    = {held_next, word.data_byte};
        uni       = {word.data_byte[6:0], held_next};

        if (p < 11'd8)
        begin
            if (word.data_byte != magic_byte(p[2:0]) && rej_base == ST_OK)
                rej_next = ST_MAGIC;
        end
        else if (p == POS_OPC_LO)
        begin
            opc_next = {8'h00, word.data_byte};
        end
        else if (p == POS_OPC_HI)
        begin
            opc_next = opc_next | {word.data_byte, 8'h00};
        end
        else if (p == POS_VER_HI || p == POS_UNI_LO || p == POS_LEN_HI)
        begin
            held_next = word.data_byte;
        end
        else if (p == POS_VER_LO)
        begin
            if (word16 != PROTO_VERSION && rej_base == ST_OK)
                rej_next = ST_VERSION;
        end
        else if (p == POS_UNI_HI)
        begin
            fwd_next = (opc_next == DMX_OPCODE) && (uni == target_universe);
        end
        else if (p == POS_LEN_LO)
        begin
            if (opc_next == DMX_OPCODE && rej_base == ST_OK &&
                (eff_len < HDR_LEN || word16 != {5'b0, eff_len - HDR_LEN}))
                rej_next = ST_LENGTH;
        end
        else if (p >= HDR_LEN)
        begin
            wr = (rej_base == ST_OK) && fwd_next && (p < eff_len) &&
                 (int'(slot_full) <= MAX_SLOTS);
        end

        // Close out a packet that ends before its checks are complete
        got = {1'b0, p} + 12'd1;
        if (word.last_byte && rej_next == ST_OK)
        begin
            if (got < {1'b0, MIN_LEN})
                rej_next = ST_SHORT;
            else if (opc_next == DMX_OPCODE && got < {1'b0, HDR_LEN})
                rej_next = ST_LENGTH;
        end

        if (word.last_byte)
            pos_next = '0;
        else
            pos_next = (p < POS_MAX) ? p + 11'd1 : POS_MAX;

        res_valid         = wr || word.last_byte;
        res.slot_write    = wr;
        res.slot_number   = wr ? slot_full[9:0] : '0;
        res.slot_value    = wr ? word.data_byte : '0;
        res.packet_done   = word.last_byte;
        res.packet_status = word.last_byte ? rej_next : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            rej_reg  <= ST_OK;
            opc_reg  <= '0;
            held_reg <= '0;
            fwd_reg  <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg  <= pos_next;
            rej_reg  <= rej_next;
            opc_reg  <= opc_next;
            held_reg <= held_next;
            fwd_reg  <= fwd_next;
        end
    end

    // A slot write always lands inside the DMX frame
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.slot_write |-> res.slot_number != '0 &&
                                   int'(res.slot_number) <= MAX_SLOTS)
        else $error("slot number out of range");

    // The last word of a packet returns the tracker to idle
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && word.last_byte |=> pos_reg == '0)
        else $error("byte position not cleared after last word");

    // Writes only come from an accepted packet
    a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.slot_write |-> rej_next == ST_OK && fwd_next)
        else $error("slot write from a rejected or foreign packet");

endmodule
`default_nettype wire

// ===== rtl/adnr_out.sv =====
`default_nettype none
// ============================================================================
// adnr_out - result register
// Holds one output word until the consumer takes it.
// ============================================================================
module adnr_out (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  load,
    input  adnr_pkg::out_word_t  res,
    output logic                 room,
    output logic                 out_valid,
    input  wire                  out_stall,
    output adnr_pkg::out_word_t  word
);
    import adnr_pkg::*;

    logic      vld_reg, vld_next;
    out_word_t word_reg;

    assign room = !vld_reg || !out_stall;

    always_comb
    begin
        if (load)
            vld_next = 1'b1;
        else if (!out_stall)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= res;
    end

    assign out_valid = vld_reg;
    assign word      = word_reg;

    // Never overwrite a word the consumer has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> room)
        else $error("result register overwritten while stalled");

    // A held word is kept until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && out_stall |=> vld_reg && $stable(word_reg))
        else $error("stalled result lost");

    // Status only rides on a done word
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        load && !res.packet_done |-> res.packet_status == ST_OK)
        else $error("status without packet done");

endmodule
`default_nettype wire

// ===== rtl/artnet_dmx_packet_receiver.sv =====
`default_nettype none
// ============================================================================
// artnet_dmx_packet_receiver - Art-Net ArtDmx receiver, one byte per word
// Checks the Art-Net header of a UDP payload and forwards the DMX data of
// the configured universe as slot writes, with a status on the last byte.
// ============================================================================
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  -----------------------------------------
//  input     in         in_valid / in_stall   data_byte, first_byte, last_byte,
//                                             packet_length
//  output    out        out_valid / out_stall slot_write, slot_number, slot_value,
//                                             packet_done, packet_status
//  config    in         cfg_write             cfg_data (target universe, 15 bits)
//
//  One word per cycle while the output is not stalled; the input register
//  feeds the header check, whose result lands in the output register.
//  A byte that yields no result (header bytes, filtered data) is consumed
//  without producing an output word.
//  out_stall holds the output register; the input register drains into it
//  in the same cycle it is taken, so in_stall rises only when both are full.
//  Reset clears valids, the tracking state and the target universe (0).
//
module artnet_dmx_packet_receiver (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  data_byte,
    input  wire         first_byte,
    input  wire         last_byte,
    input  wire  [10:0] packet_length,

    input  wire         cfg_write,
    input  wire  [14:0] cfg_data,

    output logic        out_valid,
    input  wire         out_stall,
    output logic        slot_write,
    output logic [9:0]  slot_number,
    output logic [7:0]  slot_value,
    output logic        packet_done,
    output logic [2:0]  packet_status
);
    import adnr_pkg::*;

    // Input register
    logic        in_vld_reg, in_vld_next;
    in_word_t    in_word_reg;
    logic [14:0] universe_reg;

    logic        room;
    logic        fire;
    logic        take;
    logic        res_valid;
    out_word_t   res;
    out_word_t   out_word;

    // Advance the input word whenever the output register has room
    assign fire     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        if (take)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            universe_reg <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_write)
                universe_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg.data_byte     <= data_byte;
            in_word_reg.first_byte    <= first_byte;
            in_word_reg.last_byte     <= last_byte;
            in_word_reg.packet_length <= packet_length;
        end
    end

    adnr_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .word            (in_word_reg),
        .target_universe (universe_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    adnr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word      (out_word)
    );

    assign slot_write    = out_word.slot_write;
    assign slot_number   = out_word.slot_number;
    assign slot_value    = out_word.slot_value;
    assign packet_done   = out_word.packet_done;
    assign packet_status = out_word.packet_status;

endmodule
`default_nettype wire

// ===== tb/sv/artnet_dmx_slot_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// artnet_dmx_slot_checker - slot write and status checker for the receiver
// Watches the input, output and config channels of the Art-Net receiver.
// Tracks the packet state, predicts each result word and compares it.
// ============================================================================
module artnet_dmx_slot_checker (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         in_valid,
    input  wire         in_stall,
    input  wire  [7:0]  data_byte,
    input  wire         first_byte,
    input  wire         last_byte,
    input  wire  [10:0] packet_length,

    input  wire         cfg_write,
    input  wire  [14:0] cfg_data,

    input  wire         out_valid,
    input  wire         out_stall,
    input  wire         slot_write,
    input  wire  [9:0]  slot_number,
    input  wire  [7:0]  slot_value,
    input  wire         packet_done,
    input  wire  [2:0]  packet_status,

    output int          fail_count,
    output int          pending_words,
    output int          words_checked
);
    import adnr_pkg::*;

    localparam int REPORT_LINES = 30;

    // "Art-Net" and its terminating zero
    localparam logic [7:0] ART_ID [0:7] = '{8'h41, 8'h72, 8'h74, 8'h2d,
                                           8'h4e, 8'h65, 8'h74, 8'h00};

    logic [14:0] universe_q;
    logic [10:0] byte_pos;
    status_t     status_q;
    logic [15:0] opcode_q;
    logic [7:0]  held_q;
    logic        fwd_q;

    out_word_t   slot_words_due [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= REPORT_LINES)
            $display("MISMATCH at %0t ns, word %0d: %s got %0d expected %0d",
                     $time, words_checked, what, got, want);
    endtask

    // Keep only the first reason for rejection
    function automatic void mark_reject(input status_t code);
        if (status_q == ST_OK)
            status_q = code;
    endfunction

    function automatic bit dmx_predict(input logic [7:0] b, input logic is_first,
                                       input logic is_last, input logic [10:0] plen,
                                       output out_word_t w);
        int unsigned lim;
        int unsigned p;
        int unsigned slot;
        logic [15:0] uni16;
        bit          wr;

        lim  = (plen > PKT_BUF_BYTES - 1) ? PKT_BUF_BYTES - 1 : plen;
        wr   = 1'b0;
        slot = 0;
        w    = '0;

        if (is_first || byte_pos == 0)
        begin
            p        = 0;
            status_q = ST_OK;
            opcode_q = '0;
            held_q   = '0;
            fwd_q    = 1'b0;
            if (plen < MIN_LEN)
                status_q = ST_SHORT;
        end
        else
            p = byte_pos;

        if (p < POS_OPC_LO)
        begin
            if (b != ART_ID[p])
                mark_reject(ST_MAGIC);
        end
        else if (p == POS_OPC_LO)
            opcode_q = {8'h00, b};
        else if (p == POS_OPC_HI)
            opcode_q[15:8] = b;
        else if (p == POS_VER_HI || p == POS_UNI_LO || p == POS_LEN_HI)
            held_q = b;
        else if (p == POS_VER_LO)
        begin
            if ({held_q, b} != PROTO_VERSION)
                mark_reject(ST_VERSION);
        end
        else if (p == POS_UNI_HI)
        begin
            // drop bit 15 of the universe word
            uni16 = {b, held_q};
            fwd_q = (opcode_q == DMX_OPCODE) && (uni16[14:0] == universe_q);
        end
        else if (p == POS_LEN_LO)
        begin
            if (opcode_q == DMX_OPCODE)
                if (lim < HDR_LEN || {16'h0000, held_q, b} != lim - HDR_LEN)
                    mark_reject(ST_LENGTH);
        end
        else if (p >= HDR_LEN)
        begin
            if (status_q == ST_OK && fwd_q && p < lim && p - (HDR_LEN - 1) <= MAX_SLOTS)
            begin
                wr   = 1'b1;
                slot = p - (HDR_LEN - 1);
            end
        end

        if (is_last)
        begin
            if (status_q == ST_OK)
            begin
                if (p + 1 < MIN_LEN)
                    status_q = ST_SHORT;
                else if (opcode_q == DMX_OPCODE && p + 1 < HDR_LEN)
                    status_q = ST_LENGTH;
            end
            byte_pos = '0;
        end
        else
            byte_pos = (p < POS_MAX) ? 11'(p + 1) : POS_MAX;

        w.slot_write    = wr;
        w.slot_number   = wr ? 10'(slot) : 10'd0;
        w.slot_value    = wr ? b : 8'h00;
        w.packet_done   = is_last;
        w.packet_status = is_last ? status_q : ST_OK;
        return wr || is_last;
    endfunction

    task automatic check_word();
        out_word_t want;

        words_checked++;
        if (slot_words_due.size() == 0)
        begin
            report_mismatch("word with nothing expected, slot_number", int'(slot_number), -1);
            return;
        end
        want = slot_words_due.pop_front();
        if (slot_write !== want.slot_write)
            report_mismatch("slot_write", int'(slot_write), int'(want.slot_write));
        if (slot_number !== want.slot_number)
            report_mismatch("slot_number", int'(slot_number), int'(want.slot_number));
        if (slot_value !== want.slot_value)
            report_mismatch("slot_value", int'(slot_value), int'(want.slot_value));
        if (packet_done !== want.packet_done)
            report_mismatch("packet_done", int'(packet_done), int'(want.packet_done));
        if (packet_status !== want.packet_status)
            report_mismatch("packet_status", int'(packet_status), int'(want.packet_status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t due;

        if (!rst_n)
        begin
            universe_q    = '0;
            byte_pos      = '0;
            status_q      = ST_OK;
            opcode_q      = '0;
            held_q        = '0;
            fwd_q         = 1'b0;
            fail_count    = 0;
            words_checked = 0;
            slot_words_due.delete();
            pending_words <= 0;
        end
        else
        begin
            if (cfg_write)
                universe_q = cfg_data;
            if (in_valid && !in_stall)
                if (dmx_predict(data_byte, first_byte, last_byte, packet_length, due))
                    slot_words_due.push_back(due);
            if (out_valid && !out_stall)
                check_word();
            pending_words <= slot_words_due.size();
        end
    end

endmodule

// ===== tb/sv/artnet_dmx_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// artnet_dmx_packet_receiver_tb - testbench for the Art-Net DMX receiver
// Feeds UDP payloads byte by byte: well-formed ArtDmx packets with random
// data, header rejects, early ends, restarts and noise, across several
// target universes, with random idling on both channels. A checker beside
// the block predicts every slot write and packet status and compares.
// ============================================================================
module artnet_dmx_packet_receiver_tb;

    import adnr_pkg::*;

    localparam int RAND_WORDS  = 1030;   // words in the random part
    localparam int PHASES      = 8;      // universe settings after reset
    localparam int HOLD_CYCLES = 120;    // long receiver hold-off
    localparam int QUIET_LIMIT = 2000;   // cycles with no word accepted
    localparam int OVERLONG_DATA = 600;  // data bytes of the long packet
    localparam int OVERLONG_LEN  = 560;  // packet length it claims
    localparam logic [15:0] OPC_POLL = 16'h2000;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [7:0]  data_byte     = 8'h00;
    logic        first_byte    = 1'b0;
    logic        last_byte     = 1'b0;
    logic [10:0] packet_length = 11'd1;
    logic        cfg_write     = 1'b0;
    logic [14:0] cfg_data      = 15'd0;
    logic        out_stall     = 1'b0;

    wire         in_stall;
    wire         out_valid;
    wire         slot_write;
    wire  [9:0]  slot_number;
    wire  [7:0]  slot_value;
    wire         packet_done;
    wire  [2:0]  packet_status;

    int          fail_count;
    int          pending_words;
    int          words_checked;

    // Stimulus bookkeeping
    logic [7:0]  pkt_q [$];          // bytes of the packet being built
    logic [14:0] cur_universe = '0;  // universe the block forwards now
    bit          open_packet  = 1'b0;
    bit          sender_calm  = 1'b0;
    bit          receiver_calm = 1'b0;
    bit          hold_active  = 1'b0;
    int          holds_asked  = 0;
    int          holds_done   = 0;
    int          words_sent   = 0;
    int          rand_words   = 0;
    int          packets_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    artnet_dmx_packet_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .packet_length (packet_length),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_write    (slot_write),
        .slot_number   (slot_number),
        .slot_value    (slot_value),
        .packet_done   (packet_done),
        .packet_status (packet_status)
    );

    artnet_dmx_slot_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .packet_length (packet_length),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_write    (slot_write),
        .slot_number   (slot_number),
        .slot_value    (slot_value),
        .packet_done   (packet_done),
        .packet_status (packet_status),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked)
    );

    // Idle length for either side: mostly none, often short, now and then long
    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one word and hold it until the block takes it. Valid stays high
    // into the next word unless a gap is drawn.
    task automatic send_word(input logic [7:0] b, input logic is_first, input logic is_last,
                             input logic [10:0] plen);
        int gap;
        gap = idle_len(sender_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        first_byte    <= is_first;
        last_byte     <= is_last;
        packet_length <= plen;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // Build the 18-byte ArtDmx-style header: magic, opcode (LE), version (BE),
    // sequence, physical, universe (LE), data length (BE)
    task automatic put_header(input logic [15:0] opc, input logic [15:0] uni,
                              input logic [15:0] dlen);
        string id;
        int    i;
        id = "Art-Net";
        pkt_q.delete();
        for (i = 0; i < 7; i++)
            pkt_q.push_back(id[i]);
        pkt_q.push_back(8'h00);
        pkt_q.push_back(opc[7:0]);
        pkt_q.push_back(opc[15:8]);
        pkt_q.push_back(PROTO_VERSION[15:8]);
        pkt_q.push_back(PROTO_VERSION[7:0]);
        pkt_q.push_back(8'($urandom));
        pkt_q.push_back(8'($urandom));
        pkt_q.push_back(uni[7:0]);
        pkt_q.push_back(uni[15:8]);
        pkt_q.push_back(dlen[15:8]);
        pkt_q.push_back(dlen[7:0]);
    endtask

    // Append DMX levels, leaning on the extremes now and then
    task automatic add_data(input int n);
        int i;
        int r;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 15);
            pkt_q.push_back(r == 0 ? 8'h00 : r == 1 ? 8'hff : 8'($urandom));
        end
    endtask

    task automatic cut_to(input int k);
        while (pkt_q.size() > k)
            void'(pkt_q.pop_back());
    endtask

    // Send the built packet; the first byte may carry a different length
    // than the rest, which exercises where each length is sampled.
    task automatic send_packet(input int plen_head, input int plen_tail,
                               input bit mark_first, input bit mark_last);
        int i;
        for (i = 0; i < pkt_q.size(); i++)
            send_word(pkt_q[i], mark_first && i == 0,
                      mark_last && i == pkt_q.size() - 1,
                      11'(i == 0 ? plen_head : plen_tail));
        packets_sent++;
        open_packet = !mark_last;
    endtask

    // Drop valid, let the pipeline drain, and wait until every expected
    // result word has arrived plus the block's latency.
    task automatic idle_wait();
        in_valid <= 1'b0;
        repeat (3) @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_universe(input logic [14:0] u);
        cfg_data  <= u;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_universe = u;
    endtask

    function automatic logic [14:0] phase_universe(input int ph);
        case (ph)
            0:       return 15'h7fff;
            1:       return 15'h0000;
            2:       return 15'h0001;
            3:       return 15'h4000;
            default: return 15'($urandom);
        endcase
    endfunction

    // One random packet. Close to half are well-formed ArtDmx for the current
    // universe; the rest are other universes and opcodes, rejects, early ends, restarts and noise.
    task automatic random_packet();
        int          kind;
        int          n;
        int          k;
        int          plen;
        int          sent_at_start;
        bit          mark_first;
        bit          lastf;
        logic [15:0] uni;
        logic [15:0] opc;
        logic [15:0] dlen;

        sent_at_start = words_sent;
        kind       = $urandom_range(0, 99);
        n          = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
        plen       = HDR_LEN + n;
        uni        = {1'($urandom), cur_universe};
        // a byte after a last byte starts a packet even without the mark
        mark_first = open_packet || $urandom_range(0, 9) != 0;

        if (kind < 45)
        begin
            put_header(DMX_OPCODE, uni, 16'(n));
            add_data(n);
            send_packet(plen, plen, mark_first, 1'b1);
        end
        else if (kind < 53)
        begin
            // ArtDmx for some other universe: accepted, nothing forwarded
            uni[14:0] = cur_universe ^ 15'($urandom_range(1, 32767));
            put_header(DMX_OPCODE, uni, 16'(n));
            add_data(n);
            send_packet(plen, plen, mark_first, 1'b1);
        end
        else if (kind < 61)
        begin
            // data length field disagrees with the packet length
            case ($urandom_range(0, 2))
                0:       dlen = 16'(n + 1);
                1:       dlen = 16'(n - 1);
                default: dlen = 16'($urandom);
            endcase
            put_header(DMX_OPCODE, uni, dlen);
            add_data(n);
            send_packet(plen, plen, mark_first, 1'b1);
        end
        else if (kind < 69)
        begin
            // other opcodes, any length from the minimum up
            if ($urandom_range(0, 1) == 0)
                opc = OPC_POLL;
            else
                do
                    opc = 16'($urandom);
                while (opc == DMX_OPCODE);
            put_header(opc, uni, 16'(n));
            add_data(n);
            k = $urandom_range(MIN_LEN, plen);
            cut_to(k);
            send_packet(k, k, mark_first, 1'b1);
        end
        else if (kind < 75)
        begin
            // bad magic
            put_header(DMX_OPCODE, uni, 16'(n));
            add_data(n);
            k = $urandom_range(0, 7);
            pkt_q[k] = pkt_q[k] ^ 8'($urandom_range(1, 255));
            send_packet(plen, plen, mark_first, 1'b1);
        end
        else if (kind < 80)
        begin
            // bad version, either byte
            put_header(DMX_OPCODE, uni, 16'(n));
            add_data(n);
            k = $urandom_range(0, 1) ? POS_VER_HI : POS_VER_LO;
            pkt_q[k] = pkt_q[k] ^ 8'($urandom_range(1, 255));
            send_packet(plen, plen, mark_first, 1'b1);
        end
        else if (kind < 86)
        begin
            // too short by its length, with a matching or random byte count
            put_header(DMX_OPCODE, uni, 16'(n));
            add_data(n);
            plen = $urandom_range(1, MIN_LEN - 1);
            k    = $urandom_range(0, 1) ? plen : $urandom_range(1, 20);
            cut_to(k);
            send_packet(plen, plen, mark_first, 1'b1);
        end
        else if (kind < 91)
        begin
            // last byte comes before the header is complete
            put_header($urandom_range(0, 3) != 0 ? DMX_OPCODE : OPC_POLL, uni, 16'(n));
            add_data(n);
            cut_to($urandom_range(1, HDR_LEN - 1));
            send_packet(plen, plen, mark_first, 1'b1);
        end
        else if (kind < 94)
        begin
            // leave the packet open; the next one restarts it
            put_header(DMX_OPCODE, uni, 16'(n));
            add_data(n);
            cut_to($urandom_range(1, pkt_q.size() - 1));
            send_packet(plen, plen, mark_first, 1'b0);
        end
        else if (kind < 97)
        begin
            // length of the first byte differs from the rest
            put_header(DMX_OPCODE, uni, 16'(n));
            add_data(n);
            k    = $urandom_range(0, 1) ? $urandom_range(1, MIN_LEN - 1) : plen;
            plen = plen + $urandom_range(0, 6) - 3;
            send_packet(k, plen, mark_first, 1'b1);
        end
        else
        begin
            // noise: random bytes, marks and lengths
            k     = $urandom_range(1, 30);
            lastf = 1'b0;
            repeat (k)
            begin
                lastf = $urandom_range(0, 9) == 0;
                send_word(8'($urandom), $urandom_range(0, 9) == 0, lastf,
                          11'($urandom_range(1, 2047)));
            end
            open_packet = !lastf;
        end
        rand_words += words_sent - sent_at_start;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, plus a long hold-off when asked for
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            if (holds_asked != holds_done)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                holds_done++;
            end
            else
            begin
                n = idle_len(receiver_calm);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either channel for too long
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no word accepted for %0d cycles, %0d result words still due",
                 QUIET_LIMIT, pending_words);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int ph;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: shortest packet, a one-slot ArtDmx at full level, a lone
        // byte at the largest length, and a packet started without the mark.
        sender_calm = 1'b1;
        send_word(8'h00, 1'b1, 1'b1, 11'd1);
        put_header(DMX_OPCODE, 16'h0000, 16'd1);
        pkt_q.push_back(8'hff);
        send_packet(HDR_LEN + 1, HDR_LEN + 1, 1'b1, 1'b1);
        send_word(8'h41, 1'b1, 1'b1, 11'd2047);
        send_word(8'h41, 1'b0, 1'b0, MIN_LEN);
        send_word(8'h72, 1'b0, 1'b1, MIN_LEN);
        sender_calm = 1'b0;

        for (ph = 0; ph < PHASES; ph++)
        begin
            // change the target universe only with the block drained
            idle_wait();
            write_universe(phase_universe(ph));
            sender_calm   = $urandom_range(0, 3) == 0;
            receiver_calm = $urandom_range(0, 3) == 0;

            if (ph == 1)
            begin
                // hold the receiver off while a long forwarded packet streams
                // in, so the block fills and stalls its input
                holds_asked++;
                while (!hold_active)
                    @(posedge clk);
                sender_calm = 1'b1;
                put_header(DMX_OPCODE, {1'b0, cur_universe}, 16'd60);
                add_data(60);
                send_packet(HDR_LEN + 60, HDR_LEN + 60, 1'b1, 1'b1);
                sender_calm = 1'b0;
            end

            if (ph == 3)
            begin
                // more data than slots and more bytes than the length:
                // slots past the last one are dropped, bytes past the
                // length write nothing
                put_header(DMX_OPCODE, {1'b1, cur_universe}, 16'(OVERLONG_LEN - HDR_LEN));
                add_data(OVERLONG_DATA);
                send_packet(OVERLONG_LEN, OVERLONG_LEN, 1'b1, 1'b1);
            end

            while (rand_words < RAND_WORDS * (ph + 1) / PHASES)
                random_packet();
        end

        idle_wait();

        $display("Sent %0d packets in %0d words over %0d universe settings; checked %0d result words.",
                 packets_sent, words_sent, PHASES + 1, words_checked);
        $display("Included header rejects, early ends, restarts, length changes and a packet past its length.");
        if (fail_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
